@@ design/particle_motion_step_top_macros.svh @@
// Assertion macros shared by the particle step checker.
`ifndef PARTICLE_MOTION_STEP_TOP_MACROS_SVH
`define PARTICLE_MOTION_STEP_TOP_MACROS_SVH

// The condition in one cycle implies the property in the next cycle.
`define PMS_ASSERT_NEXT(lbl, cond, nxt) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error("particle step check failed");

// The condition implies the property in the same cycle.
`define PMS_ASSERT_NOW(lbl, cond, now) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (now)) \
      else $error("particle step check failed");

`endif

@@ design/pms_pkg.sv @@
// Shared constants, types and saturation functions of the particle step block.
package pms_pkg;

   localparam int FRAC_BITS = 8;
   localparam int SIZE_W    = 12;
   localparam int DIM_W     = SIZE_W + FRAC_BITS;
   localparam int POS_W     = 20;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;

   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_START_X       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START_Y       = 3'd4;

   localparam logic [SIZE_W-1:0] RST_SCREEN_WIDTH  = 12'd1920;
   localparam logic [SIZE_W-1:0] RST_SCREEN_HEIGHT = 12'd1080;
   localparam logic [SIZE_W-1:0] RST_MAX_SPEED     = 12'd512;

   localparam int SQRT_STEPS = 17;
   localparam int DIV_STEPS  = 29;
   localparam int CNT_W      = 5;

   localparam logic [7:0] LEVEL_MAX = 8'd255;

   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_ACCEPT    = 4'd1;
   localparam logic [3:0] OP_SQX       = 4'd2;
   localparam logic [3:0] OP_SQY       = 4'd3;
   localparam logic [3:0] OP_SUM       = 4'd4;
   localparam logic [3:0] OP_CMP       = 4'd5;
   localparam logic [3:0] OP_SQRT      = 4'd6;
   localparam logic [3:0] OP_MULX      = 4'd7;
   localparam logic [3:0] OP_MULY      = 4'd8;
   localparam logic [3:0] OP_DIV_INIT  = 4'd9;
   localparam logic [3:0] OP_DIV       = 4'd10;
   localparam logic [3:0] OP_STORE_X   = 4'd11;
   localparam logic [3:0] OP_STORE_Y   = 4'd12;
   localparam logic [3:0] OP_POS       = 4'd13;
   localparam logic [3:0] OP_GREEN     = 4'd14;
   localparam logic [3:0] OP_FINISH    = 4'd15;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic clamp;
      logic green_special;
   } status_type;

   function automatic logic signed [15:0] sat_acc(input logic signed [16:0] v);
      logic signed [15:0] r;
      if (v > 17'sd32767) r = 16'sh7fff;
      else if (v < -17'sd32768) r = 16'sh8000;
      else r = 16'(v);
      return r;
   endfunction

   function automatic logic signed [12:0] sat_vel(input logic signed [16:0] v);
      logic signed [12:0] r;
      if (v > 17'sd4095) r = 13'sh0fff;
      else if (v < -17'sd4096) r = 13'sh1000;
      else r = 13'(v);
      return r;
   endfunction

   function automatic logic signed [20:0] sat_prev(input logic signed [21:0] v);
      logic signed [20:0] r;
      if (v > 22'sd1048575) r = 21'sh0fffff;
      else if (v < -22'sd1048576) r = 21'sh100000;
      else r = 21'(v);
      return r;
   endfunction

   function automatic logic signed [21:0] sat_pos(input logic signed [23:0] v);
      logic signed [21:0] r;
      if (v > 24'sd2097151) r = 22'sh1fffff;
      else if (v < -24'sd2097152) r = 22'sh200000;
      else r = 22'(v);
      return r;
   endfunction

endpackage

@@ design/pms_if.sv @@
// Request, response and register write channels of the particle step block.
interface pms_req_if;
   logic                valid;
   logic                ready;
   logic                command;
   logic signed [15:0]  force_x;
   logic signed [15:0]  force_y;
   logic signed [8:0]   jitter_x;
   logic signed [8:0]   jitter_y;
   modport source (output valid, command, force_x, force_y, jitter_x, jitter_y,
                   input ready);
   modport sink   (input valid, command, force_x, force_y, jitter_x, jitter_y,
                   output ready);
endinterface

interface pms_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] position_x;
   logic [19:0] position_y;
   logic [19:0] previous_x;
   logic [19:0] previous_y;
   logic [7:0]  green_level;
   logic        wrapped;
   modport source (output valid, position_x, position_y, previous_x, previous_y,
                   green_level, wrapped, input ready);
   modport sink   (input valid, position_x, position_y, previous_x, previous_y,
                   green_level, wrapped, output ready);
endinterface

interface pms_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [19:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/pms_ctrl.sv @@
// Sequencer that steps the particle datapath through one request.
module pms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pms_pkg::status_type  status,
   output pms_pkg::cmd_type     cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_SQX   = 5'd1;
   localparam logic [4:0] S_SQY   = 5'd2;
   localparam logic [4:0] S_SUM   = 5'd3;
   localparam logic [4:0] S_CMP   = 5'd4;
   localparam logic [4:0] S_SQRT  = 5'd5;
   localparam logic [4:0] S_MULX  = 5'd6;
   localparam logic [4:0] S_DIVXI = 5'd7;
   localparam logic [4:0] S_DIVX  = 5'd8;
   localparam logic [4:0] S_STX   = 5'd9;
   localparam logic [4:0] S_MULY  = 5'd10;
   localparam logic [4:0] S_DIVYI = 5'd11;
   localparam logic [4:0] S_DIVY  = 5'd12;
   localparam logic [4:0] S_STY   = 5'd13;
   localparam logic [4:0] S_POS   = 5'd14;
   localparam logic [4:0] S_GRNI  = 5'd15;
   localparam logic [4:0] S_GRN   = 5'd16;
   localparam logic [4:0] S_FIN   = 5'd17;

   localparam logic [pms_pkg::CNT_W-1:0] SQRT_LAST = pms_pkg::CNT_W'(pms_pkg::SQRT_STEPS - 1);
   localparam logic [pms_pkg::CNT_W-1:0] DIV_LAST  = pms_pkg::CNT_W'(pms_pkg::DIV_STEPS - 1);

   logic [4:0]                 state_ff, state_in;
   logic [pms_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [3:0]                 op;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op           = pms_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op = pms_pkg::OP_ACCEPT;
               if (req_command) state_in = S_SQX;
            end
         end
         S_SQX: begin
            op = pms_pkg::OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            op = pms_pkg::OP_SQY;
            state_in = S_SUM;
         end
         S_SUM: begin
            op = pms_pkg::OP_SUM;
            state_in = S_CMP;
         end
         S_CMP: begin
            op = pms_pkg::OP_CMP;
            cnt_in = '0;
            state_in = status.clamp ? S_SQRT : S_POS;
         end
         S_SQRT: begin
            op = pms_pkg::OP_SQRT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) state_in = S_MULX;
         end
         S_MULX: begin
            op = pms_pkg::OP_MULX;
            state_in = S_DIVXI;
         end
         S_DIVXI: begin
            op = pms_pkg::OP_DIV_INIT;
            cnt_in = '0;
            state_in = S_DIVX;
         end
         S_DIVX: begin
            op = pms_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_STX;
         end
         S_STX: begin
            op = pms_pkg::OP_STORE_X;
            state_in = S_MULY;
         end
         S_MULY: begin
            op = pms_pkg::OP_MULY;
            state_in = S_DIVYI;
         end
         S_DIVYI: begin
            op = pms_pkg::OP_DIV_INIT;
            cnt_in = '0;
            state_in = S_DIVY;
         end
         S_DIVY: begin
            op = pms_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_STY;
         end
         S_STY: begin
            op = pms_pkg::OP_STORE_Y;
            state_in = S_POS;
         end
         S_POS: begin
            op = pms_pkg::OP_POS;
            state_in = S_GRNI;
         end
         S_GRNI: begin
            op = pms_pkg::OP_GREEN;
            cnt_in = '0;
            state_in = status.green_special ? S_FIN : S_GRN;
         end
         S_GRN: begin
            op = pms_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op = pms_pkg::OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cmd.op    = op;

endmodule

@@ design/pms_dp.sv @@
// Datapath with particle state, multiplier, root and divide iterations.
module pms_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  pms_pkg::cmd_type                   cmd,
   output pms_pkg::status_type                status,
   input  logic                               in_command,
   input  logic signed [15:0]                 in_force_x,
   input  logic signed [15:0]                 in_force_y,
   input  logic signed [8:0]                  in_jitter_x,
   input  logic signed [8:0]                  in_jitter_y,
   input  logic                               cfg_we,
   input  logic [pms_pkg::CSR_IDX_W-1:0]      cfg_index,
   input  logic [pms_pkg::CSR_DAT_W-1:0]      cfg_data,
   output logic [pms_pkg::POS_W-1:0]          out_position_x,
   output logic [pms_pkg::POS_W-1:0]          out_position_y,
   output logic [pms_pkg::POS_W-1:0]          out_previous_x,
   output logic [pms_pkg::POS_W-1:0]          out_previous_y,
   output logic [7:0]                         out_green_level,
   output logic                               out_wrapped
);

   localparam int DW = pms_pkg::DIM_W;

   logic [pms_pkg::SIZE_W-1:0] sw_ff, sw_in, sh_ff, sh_in, ms_ff, ms_in;
   logic signed [21:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [20:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [12:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [15:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [16:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [8:0]  jx_ff, jx_in, jy_ff, jy_in;
   logic [32:0] mul_ff, mul_in;
   logic [33:0] s_ff, s_in;
   logic [18:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [DW-1:0] dr_ff, dr_in, dd_ff, dd_in;
   logic [28:0] dq_ff, dq_in;
   logic        gsp_ff, gsp_in;
   logic [7:0]  gval_ff, gval_in;
   logic [pms_pkg::POS_W-1:0] opx_ff, opx_in, opy_ff, opy_in, ovx_ff, ovx_in, ovy_ff, ovy_in;
   logic [7:0]  og_ff, og_in;
   logic        ow_ff, ow_in;

   logic [16:0] abs_vx, abs_vy, mul_a, mul_b;
   logic [20:0] sq_t, sq_trial;
   logic [DW:0] dv_t;
   logic [DW-1:0] w_dim, h_dim, g_d;
   logic signed [12:0] vsx, vsy;
   logic signed [22:0] px_w, py_w;
   logic wr_x, wr_y;

   assign abs_vx = vx_ff[16] ? 17'(-vx_ff) : 17'(vx_ff);
   assign abs_vy = vy_ff[16] ? 17'(-vy_ff) : 17'(vy_ff);
   assign w_dim  = {sw_ff, {pms_pkg::FRAC_BITS{1'b0}}};
   assign h_dim  = {sh_ff, {pms_pkg::FRAC_BITS{1'b0}}};
   assign vsx    = pms_pkg::sat_vel(vx_ff);
   assign vsy    = pms_pkg::sat_vel(vy_ff);
   assign sq_t     = {rem_ff, s_ff[33:32]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign dv_t     = {dr_ff, dq_ff[28]};
   assign g_d      = h_dim - DW'(pos_y_ff);

   assign status.clamp = (s_ff > 34'(mul_ff));
   assign status.green_special = (h_dim == '0) || (pos_y_ff <= 22'sd0) ||
                                 (23'(pos_y_ff) >= $signed({3'b000, h_dim}));

   always_comb begin
      case (cmd.op)
         pms_pkg::OP_SQX: begin
            mul_a = abs_vx;
            mul_b = abs_vx;
         end
         pms_pkg::OP_SQY: begin
            mul_a = abs_vy;
            mul_b = abs_vy;
         end
         pms_pkg::OP_SUM: begin
            mul_a = 17'(ms_ff);
            mul_b = 17'(ms_ff);
         end
         pms_pkg::OP_MULX: begin
            mul_a = abs_vx;
            mul_b = 17'(ms_ff);
         end
         default: begin
            mul_a = abs_vy;
            mul_b = 17'(ms_ff);
         end
      endcase
   end

   always_comb begin
      sw_in = sw_ff;   sh_in = sh_ff;   ms_in = ms_ff;
      pos_x_in = pos_x_ff;   pos_y_in = pos_y_ff;
      prev_x_in = prev_x_ff; prev_y_in = prev_y_ff;
      vel_x_in = vel_x_ff;   vel_y_in = vel_y_ff;
      acc_x_in = acc_x_ff;   acc_y_in = acc_y_ff;
      vx_in = vx_ff;   vy_in = vy_ff;   jx_in = jx_ff;   jy_in = jy_ff;
      mul_in = mul_ff; s_in = s_ff;    rem_in = rem_ff; root_in = root_ff;
      dr_in = dr_ff;   dd_in = dd_ff;  dq_in = dq_ff;
      gsp_in = gsp_ff; gval_in = gval_ff;
      opx_in = opx_ff; opy_in = opy_ff; ovx_in = ovx_ff; ovy_in = ovy_ff;
      og_in = og_ff;   ow_in = ow_ff;
      px_w = 23'(pos_x_ff);
      py_w = 23'(pos_y_ff);
      wr_x = 1'b0;
      wr_y = 1'b0;

      case (cmd.op)
         pms_pkg::OP_ACCEPT: begin
            if (in_command) begin
               vx_in = 17'(vel_x_ff) + 17'(acc_x_ff);
               vy_in = 17'(vel_y_ff) + 17'(acc_y_ff);
               jx_in = in_jitter_x;
               jy_in = in_jitter_y;
               acc_x_in = '0;
               acc_y_in = '0;
            end else begin
               acc_x_in = pms_pkg::sat_acc(17'(acc_x_ff) + 17'(in_force_x));
               acc_y_in = pms_pkg::sat_acc(17'(acc_y_ff) + 17'(in_force_y));
            end
         end
         pms_pkg::OP_SQX, pms_pkg::OP_MULX, pms_pkg::OP_MULY: begin
            mul_in = 33'(mul_a * mul_b);
         end
         pms_pkg::OP_SQY: begin
            s_in   = 34'(mul_ff);
            mul_in = 33'(mul_a * mul_b);
         end
         pms_pkg::OP_SUM: begin
            s_in   = s_ff + 34'(mul_ff);
            mul_in = 33'(mul_a * mul_b);
         end
         pms_pkg::OP_CMP: begin
            rem_in  = '0;
            root_in = '0;
         end
         pms_pkg::OP_SQRT: begin
            s_in = {s_ff[31:0], 2'b00};
            if (sq_t >= sq_trial) begin
               rem_in  = 19'(sq_t - sq_trial);
               root_in = {root_ff[15:0], 1'b1};
            end else begin
               rem_in  = sq_t[18:0];
               root_in = {root_ff[15:0], 1'b0};
            end
         end
         pms_pkg::OP_DIV_INIT: begin
            dr_in = '0;
            dd_in = DW'(root_ff);
            dq_in = 29'(mul_ff);
         end
         pms_pkg::OP_DIV: begin
            if (dv_t >= {1'b0, dd_ff}) begin
               dr_in = DW'(dv_t - {1'b0, dd_ff});
               dq_in = {dq_ff[27:0], 1'b1};
            end else begin
               dr_in = dv_t[DW-1:0];
               dq_in = {dq_ff[27:0], 1'b0};
            end
         end
         pms_pkg::OP_STORE_X: begin
            vx_in = vx_ff[16] ? -$signed(dq_ff[16:0]) : $signed(dq_ff[16:0]);
         end
         pms_pkg::OP_STORE_Y: begin
            vy_in = vy_ff[16] ? -$signed(dq_ff[16:0]) : $signed(dq_ff[16:0]);
         end
         pms_pkg::OP_POS: begin
            vel_x_in  = vsx;
            vel_y_in  = vsy;
            prev_x_in = pms_pkg::sat_prev(pos_x_ff);
            prev_y_in = pms_pkg::sat_prev(pos_y_ff);
            pos_x_in  = pms_pkg::sat_pos(24'(pos_x_ff) + 24'(vsx) + 24'(jx_ff));
            pos_y_in  = pms_pkg::sat_pos(24'(pos_y_ff) + 24'(vsy) + 24'(jy_ff));
         end
         pms_pkg::OP_GREEN: begin
            gsp_in = status.green_special;
            if (h_dim != '0 && pos_y_ff <= 22'sd0) gval_in = pms_pkg::LEVEL_MAX;
            else gval_in = '0;
            dr_in = '0;
            dd_in = h_dim;
            dq_in = 29'({g_d, 8'h00}) - 29'(g_d);
         end
         pms_pkg::OP_FINISH: begin
            if (px_w < 0) begin
               px_w = px_w + $signed({3'b000, w_dim});
               wr_x = 1'b1;
            end else if (px_w >= $signed({3'b000, w_dim})) begin
               px_w = px_w - $signed({3'b000, w_dim});
               wr_x = 1'b1;
            end
            if (py_w < 0) begin
               py_w = py_w + $signed({3'b000, h_dim});
               wr_y = 1'b1;
            end else if (py_w >= $signed({3'b000, h_dim})) begin
               py_w = py_w - $signed({3'b000, h_dim});
               wr_y = 1'b1;
            end
            pos_x_in = 22'(px_w);
            pos_y_in = 22'(py_w);
            if (wr_x || wr_y) begin
               prev_x_in = pms_pkg::sat_prev(22'(px_w));
               prev_y_in = pms_pkg::sat_prev(22'(py_w));
            end
            opx_in = px_w[19:0];
            opy_in = py_w[19:0];
            ovx_in = (wr_x || wr_y) ? prev_x_in[19:0] : prev_x_ff[19:0];
            ovy_in = (wr_x || wr_y) ? prev_y_in[19:0] : prev_y_ff[19:0];
            og_in  = gsp_ff ? gval_ff : dq_ff[7:0];
            ow_in  = wr_x || wr_y;
         end
         default: begin
         end
      endcase

      if (cfg_we) begin
         unique case (cfg_index)
            pms_pkg::REG_SCREEN_WIDTH:  sw_in = cfg_data[pms_pkg::SIZE_W-1:0];
            pms_pkg::REG_SCREEN_HEIGHT: sh_in = cfg_data[pms_pkg::SIZE_W-1:0];
            pms_pkg::REG_MAX_SPEED:     ms_in = cfg_data[pms_pkg::SIZE_W-1:0];
            pms_pkg::REG_START_X: begin
               pos_x_in  = 22'($signed({1'b0, cfg_data}));
               prev_x_in = 21'($signed({1'b0, cfg_data}));
            end
            pms_pkg::REG_START_Y: begin
               pos_y_in  = 22'($signed({1'b0, cfg_data}));
               prev_y_in = 21'($signed({1'b0, cfg_data}));
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= pms_pkg::RST_SCREEN_WIDTH;
         sh_ff <= pms_pkg::RST_SCREEN_HEIGHT;
         ms_ff <= pms_pkg::RST_MAX_SPEED;
         pos_x_ff <= '0;  pos_y_ff <= '0;
         prev_x_ff <= '0; prev_y_ff <= '0;
         vel_x_ff <= '0;  vel_y_ff <= '0;
         acc_x_ff <= '0;  acc_y_ff <= '0;
      end else begin
         sw_ff <= sw_in;  sh_ff <= sh_in;  ms_ff <= ms_in;
         pos_x_ff <= pos_x_in;   pos_y_ff <= pos_y_in;
         prev_x_ff <= prev_x_in; prev_y_ff <= prev_y_in;
         vel_x_ff <= vel_x_in;   vel_y_ff <= vel_y_in;
         acc_x_ff <= acc_x_in;   acc_y_ff <= acc_y_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff <= vx_in;   vy_ff <= vy_in;   jx_ff <= jx_in;   jy_ff <= jy_in;
      mul_ff <= mul_in; s_ff <= s_in;     rem_ff <= rem_in; root_ff <= root_in;
      dr_ff <= dr_in;   dd_ff <= dd_in;   dq_ff <= dq_in;
      gsp_ff <= gsp_in; gval_ff <= gval_in;
      opx_ff <= opx_in; opy_ff <= opy_in; ovx_ff <= ovx_in; ovy_ff <= ovy_in;
      og_ff <= og_in;   ow_ff <= ow_in;
   end

   assign out_position_x  = opx_ff;
   assign out_position_y  = opy_ff;
   assign out_previous_x  = ovx_ff;
   assign out_previous_y  = ovy_ff;
   assign out_green_level = og_ff;
   assign out_wrapped     = ow_ff;

endmodule

@@ design/particle_motion_step_top.sv @@
// Top level of the fixed-point particle step block.
// An add-force request gives no response. A tick request with the speed not above the
// limit and the new y outside the open screen height range takes the shortest path; a new y
// strictly inside that range adds a divide, and a speed clamp adds a square root (two
// radicand bits per cycle) and two component divides. The rate is set by the single shared
// restoring divider, which yields one quotient bit per cycle, and by the shared 17 by 17 bit
// multiplier. The response sits in an output register, and a new request is accepted while
// that response waits.
module particle_motion_step_top (
   input  logic        clock,
   input  logic        reset,
   pms_req_if.sink     req_ch,
   pms_rsp_if.source   rsp_ch,
   pms_csr_if.sink     csr_ch
);

   pms_pkg::cmd_type    cmd;
   pms_pkg::status_type status;

   assign csr_ch.ready = 1'b1;

   pms_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .status      (status),
      .cmd         (cmd)
   );

   pms_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_command      (req_ch.command),
      .in_force_x      (req_ch.force_x),
      .in_force_y      (req_ch.force_y),
      .in_jitter_x     (req_ch.jitter_x),
      .in_jitter_y     (req_ch.jitter_y),
      .cfg_we          (csr_ch.valid),
      .cfg_index       (csr_ch.index),
      .cfg_data        (csr_ch.data),
      .out_position_x  (rsp_ch.position_x),
      .out_position_y  (rsp_ch.position_y),
      .out_previous_x  (rsp_ch.previous_x),
      .out_previous_y  (rsp_ch.previous_y),
      .out_green_level (rsp_ch.green_level),
      .out_wrapped     (rsp_ch.wrapped)
   );

endmodule

@@ design/pms_checker.sv @@
// Port-level checks of the particle step block and their binding.
`include "particle_motion_step_top_macros.svh"

module pms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [19:0] rsp_position_x
);

   `PMS_ASSERT_NEXT(rsp_hold_a, rsp_valid && !rsp_ready, rsp_valid)
   `PMS_ASSERT_NEXT(rsp_stable_a, rsp_valid && !rsp_ready, $stable(rsp_position_x))
   `PMS_ASSERT_NEXT(force_quiet_a, req_valid && req_ready && !req_command && !rsp_valid, !rsp_valid)
   `PMS_ASSERT_NEXT(tick_busy_a, req_valid && req_ready && req_command, !req_ready)

endmodule

bind particle_motion_step_top pms_checker u_pms_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_command    (req_ch.command),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_position_x (rsp_ch.position_x)
);
